// File: src/i2c_master_bit_engine_assert.svh
// assertion macros for the i2c master bit engine checker
// expects i_clk and i_rst_n in the scope of use
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// checked outside reset
`define I2CM_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define I2CM_CHK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/i2cm_pkg.sv
// shared types and constants for the i2c master bit engine
// no dependencies
package i2cm_pkg;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [1:0] CFG_HALF_DELAY  = 2'd0;
    localparam logic [1:0] CFG_ACK_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_WRITE_SETUP = 2'd2;

    localparam logic [7:0] HALF_DELAY_RST = 8'd10;
    localparam logic [7:0] ACK_LIMIT_RST  = 8'd200;

    typedef enum logic [2:0] {
        K_TICK,
        K_START,
        K_STOP,
        K_WRITE,
        K_READ
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST1,
        PH_ST2,
        PH_SP1,
        PH_SP2,
        PH_WL,
        PH_WH,
        PH_AK1,
        PH_AK2,
        PH_AKP,
        PH_RL,
        PH_RH,
        PH_RA1,
        PH_RA2
    } t_phase;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic       ack_sel;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       ack_sel;
        logic       sda_in;
    } t_q_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       ack_ok;
        logic [7:0] read_byte;
        logic       rejected;
    } t_out_item;

endpackage

// File: src/i2cm_front.sv
// front end: accepts input transactions and classifies the command code
// depends on i2cm_pkg
module i2cm_front import i2cm_pkg::*; (
    input  logic     i_in_valid,
    input  t_in_item i_in,
    input  logic     i_q_full,
    output logic     o_in_stall,
    output logic     o_q_push,
    output t_q_item  o_q_item
);

    t_kind s_kind;

    always_comb begin
        unique case (i_in.command)
            CMD_START: s_kind = K_START;
            CMD_STOP:  s_kind = K_STOP;
            CMD_WRITE: s_kind = K_WRITE;
            CMD_READ:  s_kind = K_READ;
            default:   s_kind = K_TICK;
        endcase
    end

    assign o_in_stall          = i_q_full;
    assign o_q_push            = i_in_valid & ~i_q_full;
    assign o_q_item.kind       = s_kind;
    assign o_q_item.data_byte  = i_in.data_byte;
    assign o_q_item.ack_sel    = i_in.ack_sel;
    assign o_q_item.sda_in     = i_in.sda_in;

endmodule

// File: src/i2cm_queue.sv
// two-entry queue between front end and bus engine
// depends on i2cm_pkg
module i2cm_queue import i2cm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_item i_item,
    input  logic    i_pop,
    output logic    o_valid,
    output logic    o_full,
    output t_q_item o_item
);

    t_q_item    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_valid = r_count != 2'd0;
    assign o_full  = r_count[1];
    assign o_item  = r_mem[r_rd_ptr];

endmodule

// File: src/i2cm_back.sv
// back end: bus phase sequencer, pin registers, config registers, result register
// depends on i2cm_pkg
module i2cm_back import i2cm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_q_item   i_q_item,
    output logic      o_q_pop,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic [7:0] r_half_delay;
    logic [7:0] r_ack_limit;
    logic       r_wsetup;

    t_phase     r_phase, n_phase;
    logic [7:0] r_wait, n_wait;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [8:0] r_polls, n_polls;
    logic       r_ack_choice, n_ack_choice;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_sda_oe, n_sda_oe;
    logic       r_ack_status, n_ack_status;
    logic [7:0] r_read_hold, n_read_hold;

    logic       r_out_valid, n_out_valid;
    t_out_item  r_out;

    logic       s_fire;
    logic       s_is_cmd;
    logic       s_step;
    logic [3:0] s_bit_inc;
    logic [8:0] s_polls_inc;
    logic       s_enter;
    t_phase     s_enter_ph;
    logic       s_done;
    logic       s_rej;

    assign s_fire      = i_q_valid & (~r_out_valid | ~i_out_stall);
    assign s_is_cmd    = i_q_item.kind != K_TICK;
    assign s_step      = s_fire && r_phase != PH_IDLE && r_phase != PH_AKP && r_wait == 8'd0;
    assign s_bit_inc   = r_bit + 4'd1;
    assign s_polls_inc = r_polls + 9'd1;
    assign o_q_pop     = s_fire;

    // next phase
    always_comb begin
        s_done     = 1'b0;
        s_rej      = 1'b0;
        s_enter    = 1'b0;
        s_enter_ph = r_phase;
        n_phase    = r_phase;
        if (s_fire) begin
            if (r_phase != PH_IDLE) begin
                s_rej = s_is_cmd;
                if (r_phase == PH_AKP) begin
                    if (!i_q_item.sda_in || s_polls_inc > {1'b0, r_ack_limit}) begin
                        n_phase = PH_IDLE;
                        s_done  = 1'b1;
                    end
                end else if (r_wait == 8'd0) begin
                    unique case (r_phase)
                        PH_ST1: begin s_enter = 1'b1; s_enter_ph = PH_ST2; end
                        PH_SP1: begin s_enter = 1'b1; s_enter_ph = PH_SP2; end
                        PH_WL:  begin s_enter = 1'b1; s_enter_ph = PH_WH; end
                        PH_WH: begin
                            s_enter    = 1'b1;
                            s_enter_ph = s_bit_inc[3] ? PH_AK1 : PH_WL;
                        end
                        PH_AK1: begin s_enter = 1'b1; s_enter_ph = PH_AK2; end
                        PH_AK2: begin s_enter = 1'b1; s_enter_ph = PH_AKP; end
                        PH_RL:  begin s_enter = 1'b1; s_enter_ph = PH_RH; end
                        PH_RH: begin
                            s_enter    = 1'b1;
                            s_enter_ph = s_bit_inc[3] ? PH_RA1 : PH_RL;
                        end
                        PH_RA1: begin s_enter = 1'b1; s_enter_ph = PH_RA2; end
                        PH_ST2, PH_SP2, PH_RA2: begin
                            n_phase = PH_IDLE;
                            s_done  = 1'b1;
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end else begin
                unique case (i_q_item.kind)
                    K_START: begin s_enter = 1'b1; s_enter_ph = PH_ST1; end
                    K_STOP:  begin s_enter = 1'b1; s_enter_ph = PH_SP1; end
                    K_WRITE: begin s_enter = 1'b1; s_enter_ph = PH_WL; end
                    K_READ:  begin s_enter = 1'b1; s_enter_ph = PH_RL; end
                    default: ;
                endcase
            end
            if (s_enter) begin
                n_phase = s_enter_ph;
            end
        end
    end

    // datapath and pin registers
    always_comb begin
        n_wait       = r_wait;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_polls      = r_polls;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_sda_oe     = r_sda_oe;
        n_ack_status = r_ack_status;
        n_read_hold  = r_read_hold;

        if (s_fire && r_phase == PH_AKP) begin
            if (!i_q_item.sda_in) begin
                n_scl        = 1'b0;
                n_ack_status = 1'b1;
            end else begin
                n_polls = s_polls_inc;
                if (s_polls_inc > {1'b0, r_ack_limit}) begin
                    n_ack_status = 1'b0;
                end
            end
        end else if (s_fire && r_phase != PH_IDLE && r_wait != 8'd0) begin
            n_wait = r_wait - 8'd1;
        end

        if (s_step) begin
            case (r_phase)
                PH_ST2: n_scl = 1'b0;
                PH_SP2: n_sda = 1'b1;
                PH_WH: begin
                    n_scl   = 1'b0;
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = s_bit_inc;
                end
                PH_RH: begin
                    n_scl   = 1'b0;
                    n_shift = {r_shift[6:0], i_q_item.sda_in};
                    n_bit   = s_bit_inc;
                end
                PH_RA2: begin
                    n_scl       = 1'b0;
                    n_read_hold = r_shift;
                end
                default: ;
            endcase
        end

        if (s_fire && r_phase == PH_IDLE) begin
            case (i_q_item.kind)
                K_WRITE: begin
                    n_sda_oe = 1'b1;
                    n_shift  = i_q_item.data_byte;
                    n_bit    = 4'd0;
                    n_polls  = 9'd0;
                end
                K_READ: begin
                    n_sda_oe     = 1'b0;
                    n_shift      = 8'd0;
                    n_bit        = 4'd0;
                    n_ack_choice = i_q_item.ack_sel;
                end
                default: ;
            endcase
        end

        if (s_enter) begin
            n_wait = r_half_delay;
            case (s_enter_ph)
                PH_ST1: begin
                    n_sda_oe = 1'b1;
                    n_sda    = 1'b1;
                    n_scl    = 1'b1;
                end
                PH_ST2: n_sda = 1'b0;
                PH_SP1: begin
                    n_sda_oe = 1'b1;
                    n_scl    = 1'b0;
                    n_sda    = 1'b0;
                end
                PH_SP2: n_scl = 1'b1;
                PH_WL: begin
                    n_sda  = n_shift[7];
                    n_wait = r_wsetup ? r_half_delay : 8'd0;
                end
                PH_WH:  n_scl = 1'b1;
                PH_AK1: n_sda_oe = 1'b0;
                PH_AK2: n_scl = 1'b1;
                PH_AKP: n_wait = 8'd0;
                PH_RH:  n_scl = 1'b1;
                PH_RA1: begin
                    n_sda_oe = 1'b1;
                    n_sda    = ~n_ack_choice;
                end
                PH_RA2: n_scl = 1'b1;
                default: ;
            endcase
        end
    end

    assign n_out_valid = s_fire | (r_out_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_wait       <= 8'd0;
            r_bit        <= 4'd0;
            r_shift      <= 8'd0;
            r_polls      <= 9'd0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_sda_oe     <= 1'b1;
            r_ack_status <= 1'b0;
            r_read_hold  <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_wait       <= n_wait;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_polls      <= n_polls;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_sda_oe     <= n_sda_oe;
            r_ack_status <= n_ack_status;
            r_read_hold  <= n_read_hold;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out.scl_level <= n_scl;
            r_out.sda_level <= n_sda_oe ? n_sda : 1'b1;
            r_out.sda_drive <= n_sda_oe;
            r_out.busy_res  <= n_phase != PH_IDLE;
            r_out.done_res  <= s_done;
            r_out.ack_ok    <= n_ack_status;
            r_out.read_byte <= n_read_hold;
            r_out.rejected  <= s_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_delay <= HALF_DELAY_RST;
            r_ack_limit  <= ACK_LIMIT_RST;
            r_wsetup     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HALF_DELAY:  r_half_delay <= i_cfg_data;
                CFG_ACK_LIMIT:   r_ack_limit  <= i_cfg_data;
                CFG_WRITE_SETUP: r_wsetup     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: src/i2c_master_bit_engine.sv
// top level of the i2c master bit engine
// depends on i2cm_pkg, i2cm_front, i2cm_queue, i2cm_back
//
// channel  direction  handshake                    payload
// in       input      i_in_valid / o_in_stall      t_in_item  i_in
// out      output     o_out_valid / i_out_stall    t_out_item o_out
// cfg      input      i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// one transaction per cycle unless i_out_stall; each steps the sequencer or its wait
// an accepted input is written into the queue, then into the result register
// o_in_stall rises only while the two-entry queue is full
// i_out_stall holds the result register and backs up into the queue
// synchronous active-low reset returns the bus to idle with scl and sda high
module i2c_master_bit_engine import i2cm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    logic    s_q_full;
    logic    s_q_push;
    t_q_item s_q_in;
    logic    s_q_valid;
    logic    s_q_pop;
    t_q_item s_q_out;

    i2cm_front u_front (
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_q_full   (s_q_full),
        .o_in_stall (o_in_stall),
        .o_q_push   (s_q_push),
        .o_q_item   (s_q_in)
    );

    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_q_push),
        .i_item  (s_q_in),
        .i_pop   (s_q_pop),
        .o_valid (s_q_valid),
        .o_full  (s_q_full),
        .o_item  (s_q_out)
    );

    i2cm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (s_q_valid),
        .i_q_item    (s_q_out),
        .o_q_pop     (s_q_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// File: src/i2cm_checker.sv
// port-level checks for the i2c master bit engine, bound to the top level
// depends on i2cm_pkg and i2c_master_bit_engine_assert.svh
`include "i2c_master_bit_engine_assert.svh"

module i2cm_checker import i2cm_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input t_in_item   i_in,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_out_item  o_out
);

    `I2CM_CHK(a_in_hold,
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in),
        "stalled input changed")
    `I2CM_CHK(a_out_hold,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out),
        "stalled result changed")
    `I2CM_CHK(a_done_idle, o_out_valid && o_out.done_res |-> !o_out.busy_res,
        "done while still busy")
    `I2CM_CHK(a_released_high, o_out_valid && !o_out.sda_drive |-> o_out.sda_level,
        "released sda not high")
    `I2CM_CHK_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind i2c_master_bit_engine i2cm_checker u_chk (.*);
